@@ src/positional_list_engine_top_assert.svh @@
// Assertion macros used by the checker file.
`ifndef POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PLE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/ple_pkg.sv @@
package ple_pkg;

   localparam int CAPACITY_DEF   = 16;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int MODE_W   = 2;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT   = 2'd0,
      MODE_REMOVE   = 2'd1,
      MODE_GET      = 2'd2,
      MODE_CONTAINS = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_POS = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_EMPTY   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSERT,
      ST_REMOVE,
      ST_GET,
      ST_SEARCH,
      ST_DONE
   } state_type;

endpackage

@@ src/positional_list_engine_top.sv @@
// Ordered list of up to CAPACITY words, addressed by 1-based position.
// Request channel (req_*): mode, position, value; a transfer happens when
// req_valid is high and req_stall is low. req_stall stays high from the
// transfer until the request has finished and its response is registered.
// Response channel (rsp_*): one response per request, carrying the read
// word, the found flag, the entry count after the request and a status.
// Entries live in a single-port-write, single-port-read memory with a
// registered read; one shared read/write step moves one entry per cycle.
// A new request can be taken in the same cycle as the earliest response
// transfer. Error cases go straight to the done step; a get reads one entry;
// a contains reads entries until a match; an insert at position p moves the
// entries from p up by one slot; a remove at p moves those above it down.
// The worst case is a contains with no match in a full list, set by the
// one-entry-per-cycle memory walk.
// A stalled response holds in the output register; the finished request
// waits in the done step until the register frees, then the next request
// is taken. Reset empties the list (count to zero) and drops any pending
// response; memory contents are not cleared and need no clearing pass.
module positional_list_engine_top #(
   parameter int CAPACITY   = ple_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ple_pkg::MODE_W-1:0]    req_mode,
   input  logic [ple_pkg::POS_W-1:0]     req_position,
   input  logic [ple_pkg::VALUE_W-1:0]   req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ple_pkg::VALUE_W-1:0]   rsp_read_value,
   output logic                          rsp_found,
   output logic [ple_pkg::COUNT_W-1:0]   rsp_entry_count,
   output logic [ple_pkg::STATUS_W-1:0]  rsp_status
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int AW   = $clog2(CAPACITY);
   localparam int CMPW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;

   ple_pkg::state_type  state_ff, state_in;
   ple_pkg::mode_type   mode_ff, mode_in;
   ple_pkg::status_type status_ff, status_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         ptr_ff, ptr_in;
   logic [CW-1:0]         pidx_ff, pidx_in;
   logic                  pend_ff, pend_in;
   logic                  found_ff, found_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [DATA_WIDTH-1:0] rdval_ff, rdval_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ple_pkg::VALUE_W-1:0] rsp_read_value_ff, rsp_read_value_in;
   logic                        rsp_found_ff, rsp_found_in;
   logic [ple_pkg::COUNT_W-1:0] rsp_entry_count_ff, rsp_entry_count_in;
   ple_pkg::status_type         rsp_status_ff, rsp_status_in;

   logic [DATA_WIDTH-1:0] mem [CAPACITY];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  rd_en, wr_en;
   logic [CW-1:0]         rd_addr, wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;

   logic            accept, out_free;
   logic [63:0]     req_value_ext, rdval_ext;
   logic [CMPW-1:0] pos_x, cnt_x;
   logic            list_empty, list_full;
   logic [CW-1:0]   ptr_dec, ptr_dec2, ptr_inc, ptr_inc2;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign req_value_ext = 64'(req_value);
   assign rdval_ext     = 64'(rdval_ff);
   assign pos_x         = CMPW'(req_position);
   assign cnt_x         = CMPW'(count_ff);
   assign list_empty    = (count_ff == '0);
   assign list_full     = (count_ff >= CW'(CAPACITY));

   assign ptr_dec  = ptr_ff - CW'(1);
   assign ptr_dec2 = ptr_ff - CW'(2);
   assign ptr_inc  = ptr_ff + CW'(1);
   assign ptr_inc2 = ptr_ff + CW'(2);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr[AW-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ple_pkg::ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff            <= mode_in;
      status_ff          <= status_in;
      ptr_ff             <= ptr_in;
      pidx_ff            <= pidx_in;
      found_ff           <= found_in;
      val_ff             <= val_in;
      rdval_ff           <= rdval_in;
      rsp_read_value_ff  <= rsp_read_value_in;
      rsp_found_ff       <= rsp_found_in;
      rsp_entry_count_ff <= rsp_entry_count_in;
      rsp_status_ff      <= rsp_status_in;
   end

   always_comb begin
      state_in           = state_ff;
      mode_in            = mode_ff;
      status_in          = status_ff;
      count_in           = count_ff;
      ptr_in             = ptr_ff;
      pidx_in            = pidx_ff;
      pend_in            = pend_ff;
      found_in           = found_ff;
      val_in             = val_ff;
      rdval_in           = rdval_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_read_value_in  = rsp_read_value_ff;
      rsp_found_in       = rsp_found_ff;
      rsp_entry_count_in = rsp_entry_count_ff;
      rsp_status_in      = rsp_status_ff;
      rd_en              = 1'b0;
      rd_addr            = ptr_ff;
      wr_en              = 1'b0;
      wr_addr            = ptr_ff;
      wr_data            = val_ff;
      req_stall          = (state_ff != ple_pkg::ST_IDLE);

      case (state_ff)
         ple_pkg::ST_IDLE: begin
            if (accept) begin
               mode_in   = ple_pkg::mode_type'(req_mode);
               val_in    = req_value_ext[DATA_WIDTH-1:0];
               found_in  = 1'b0;
               rdval_in  = '0;
               pend_in   = 1'b0;
               status_in = ple_pkg::STATUS_OK;
               pidx_in   = CW'(pos_x - CMPW'(1));
               state_in  = ple_pkg::ST_DONE;
               case (ple_pkg::mode_type'(req_mode))
                  ple_pkg::MODE_INSERT: begin
                     if (list_full) begin
                        status_in = ple_pkg::STATUS_FULL;
                     end else if (list_empty) begin
                        // position is ignored on an empty list
                        pidx_in  = '0;
                        ptr_in   = '0;
                        state_in = ple_pkg::ST_INSERT;
                     end else if (pos_x == '0 || pos_x > cnt_x + CMPW'(1)) begin
                        status_in = ple_pkg::STATUS_BAD_POS;
                     end else begin
                        ptr_in   = count_ff;
                        state_in = ple_pkg::ST_INSERT;
                     end
                  end
                  ple_pkg::MODE_REMOVE,
                  ple_pkg::MODE_GET: begin
                     if (list_empty) begin
                        status_in = ple_pkg::STATUS_EMPTY;
                     end else if (pos_x == '0 || pos_x > cnt_x) begin
                        status_in = ple_pkg::STATUS_BAD_POS;
                     end else begin
                        ptr_in   = CW'(pos_x - CMPW'(1));
                        state_in = (ple_pkg::mode_type'(req_mode) == ple_pkg::MODE_REMOVE)
                                   ? ple_pkg::ST_REMOVE : ple_pkg::ST_GET;
                     end
                  end
                  default: begin
                     ptr_in   = '0;
                     state_in = ple_pkg::ST_SEARCH;
                  end
               endcase
            end
         end

         ple_pkg::ST_INSERT: begin
            if (!pend_ff) begin
               if (ptr_ff == pidx_ff) begin
                  wr_en    = 1'b1;
                  wr_addr  = ptr_ff;
                  wr_data  = val_ff;
                  state_in = ple_pkg::ST_DONE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = ptr_dec;
                  pend_in = 1'b1;
               end
            end else begin
               // move entry back one slot, fetch the next one down
               wr_en   = 1'b1;
               wr_addr = ptr_ff;
               wr_data = rd_data_ff;
               ptr_in  = ptr_dec;
               if (ptr_dec > pidx_ff) begin
                  rd_en   = 1'b1;
                  rd_addr = ptr_dec2;
               end else begin
                  pend_in = 1'b0;
               end
            end
         end

         ple_pkg::ST_REMOVE: begin
            if (!pend_ff) begin
               if (ptr_inc >= count_ff) begin
                  state_in = ple_pkg::ST_DONE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = ptr_inc;
                  pend_in = 1'b1;
               end
            end else begin
               wr_en   = 1'b1;
               wr_addr = ptr_ff;
               wr_data = rd_data_ff;
               ptr_in  = ptr_inc;
               if (ptr_inc2 < count_ff) begin
                  rd_en   = 1'b1;
                  rd_addr = ptr_inc2;
               end else begin
                  pend_in = 1'b0;
               end
            end
         end

         ple_pkg::ST_GET: begin
            if (!pend_ff) begin
               rd_en   = 1'b1;
               rd_addr = pidx_ff;
               pend_in = 1'b1;
            end else begin
               rdval_in = rd_data_ff;
               pend_in  = 1'b0;
               state_in = ple_pkg::ST_DONE;
            end
         end

         ple_pkg::ST_SEARCH: begin
            if (!pend_ff) begin
               if (ptr_ff >= count_ff) begin
                  state_in = ple_pkg::ST_DONE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = ptr_ff;
                  pend_in = 1'b1;
               end
            end else if (rd_data_ff == val_ff) begin
               found_in = 1'b1;
               pend_in  = 1'b0;
               state_in = ple_pkg::ST_DONE;
            end else begin
               ptr_in = ptr_inc;
               if (ptr_inc < count_ff) begin
                  rd_en   = 1'b1;
                  rd_addr = ptr_inc;
               end else begin
                  pend_in = 1'b0;
               end
            end
         end

         ple_pkg::ST_DONE: begin
            // hold until the response register can take the transfer
            if (out_free) begin
               if (status_ff == ple_pkg::STATUS_OK && mode_ff == ple_pkg::MODE_INSERT) begin
                  count_in = count_ff + CW'(1);
               end else if (status_ff == ple_pkg::STATUS_OK &&
                            mode_ff == ple_pkg::MODE_REMOVE) begin
                  count_in = count_ff - CW'(1);
               end
               rsp_valid_in       = 1'b1;
               rsp_read_value_in  = rdval_ext[ple_pkg::VALUE_W-1:0];
               rsp_found_in       = found_ff;
               rsp_entry_count_in = ple_pkg::COUNT_W'(count_in);
               rsp_status_in      = status_ff;
               state_in           = ple_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ple_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

@@ src/ple_checker.sv @@
`include "positional_list_engine_top_assert.svh"

module ple_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [ple_pkg::VALUE_W-1:0]   rsp_read_value,
   input logic                          rsp_found,
   input logic [ple_pkg::COUNT_W-1:0]   rsp_entry_count,
   input logic [ple_pkg::STATUS_W-1:0]  rsp_status
);

   localparam int RSP_W = 2 + ple_pkg::VALUE_W + ple_pkg::COUNT_W + ple_pkg::STATUS_W;

   logic             req_xfer;
   logic             rsp_err;
   logic             rsp_hit;
   logic             rd_zero;
   logic             rsp_clean;
   logic             rsp_held;
   logic [RSP_W-1:0] rsp_word;

   assign req_xfer  = req_valid && !req_stall;
   assign rsp_err   = rsp_valid && (rsp_status != ple_pkg::STATUS_OK);
   assign rsp_hit   = rsp_valid && rsp_found;
   assign rd_zero   = (rsp_read_value == '0);
   assign rsp_clean = rd_zero && !rsp_found;
   assign rsp_held  = rsp_valid && rsp_stall;
   assign rsp_word  = {rsp_valid, rsp_read_value, rsp_found, rsp_entry_count, rsp_status};

   // an accepted request blocks the request channel
   `PLE_ASSERT_NEXT(a_busy_after_req, clock, reset, req_xfer, req_stall, "accepted while busy")

   // a failed request carries no read word and no found flag
   `PLE_ASSERT_SAME(a_error_clean, clock, reset, rsp_err, rsp_clean, "error carries data")

   `PLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, $stable(rsp_word), "stalled rsp moved")

   // a found flag only comes with a clean read word
   `PLE_ASSERT_SAME(a_found_no_read, clock, reset, rsp_hit, rd_zero, "found with read word")

endmodule

bind positional_list_engine_top ple_checker u_ple_checker (.*);

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;

   localparam int LIST_CAP    = ple_pkg::CAPACITY_DEF;
   localparam int WORD_W      = ple_pkg::VALUE_W;
   localparam int HOLD_LEN    = 300;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      ple_pkg::mode_type             mode;
      logic [ple_pkg::POS_W-1:0]     position;
      logic [ple_pkg::VALUE_W-1:0]   value;
   } list_req_type;

   typedef struct packed {
      logic [ple_pkg::VALUE_W-1:0]   read_value;
      logic                          found;
      logic [ple_pkg::COUNT_W-1:0]   entry_count;
      ple_pkg::status_type           status;
   } list_rsp_type;

   typedef struct packed {
      list_req_type req;
      logic         typed;
      list_rsp_type rsp;
   } script_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [ple_pkg::MODE_W-1:0]      req_mode = '0;
   logic [ple_pkg::POS_W-1:0]       req_position = '0;
   logic [ple_pkg::VALUE_W-1:0]     req_value = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [ple_pkg::VALUE_W-1:0]     rsp_read_value;
   logic                            rsp_found;
   logic [ple_pkg::COUNT_W-1:0]     rsp_entry_count;
   logic [ple_pkg::STATUS_W-1:0]    rsp_status;

   // shadow copy of the list
   logic [ple_pkg::VALUE_W-1:0]     list_words [LIST_CAP];
   int                              list_count = 0;
   bit                              filling = 1'b1;

   list_rsp_type          pending_rsps [$];
   script_row_type        script_rows [$];
   list_rsp_type          arrived;
   int                    errors = 0;
   int                    cycle_count = 0;
   int                    gap_pct = 0;
   int                    stall_pct = 0;
   int                    holds_asked = 0;
   int                    holds_done = 0;
   int                    hold_left = 0;

   positional_list_engine_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_value  (rsp_read_value),
      .rsp_found       (rsp_found),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                  logic [WORD_W-1:0] want);
      $display("tb: mismatch on %s: got %0h, expected %0h", what, got, want);
      errors++;
   endtask

   // Apply one request to the shadow list and return its response.
   task automatic list_apply(input list_req_type r, output list_rsp_type o);
      int i;
      o = '0;
      o.status = ple_pkg::STATUS_OK;
      case (r.mode)
         ple_pkg::MODE_INSERT: begin
            if (list_count >= LIST_CAP) begin
               o.status = ple_pkg::STATUS_FULL;
            end else if (list_count == 0) begin
               list_words[0] = r.value;
               list_count = 1;
            end else if (r.position < 1 || r.position > list_count + 1) begin
               o.status = ple_pkg::STATUS_BAD_POS;
            end else begin
               for (i = list_count; i >= r.position; i--)
                  list_words[i] = list_words[i-1];
               list_words[r.position-1] = r.value;
               list_count++;
            end
         end
         ple_pkg::MODE_REMOVE: begin
            if (list_count == 0) begin
               o.status = ple_pkg::STATUS_EMPTY;
            end else if (r.position < 1 || r.position > list_count) begin
               o.status = ple_pkg::STATUS_BAD_POS;
            end else begin
               for (i = r.position - 1; i + 1 < list_count; i++)
                  list_words[i] = list_words[i+1];
               list_count--;
            end
         end
         ple_pkg::MODE_GET: begin
            if (list_count == 0)
               o.status = ple_pkg::STATUS_EMPTY;
            else if (r.position < 1 || r.position > list_count)
               o.status = ple_pkg::STATUS_BAD_POS;
            else
               o.read_value = list_words[r.position-1];
         end
         default: begin
            for (i = 0; i < list_count; i++)
               if (list_words[i] == r.value)
                  o.found = 1'b1;
         end
      endcase
      o.entry_count = 5'(list_count);
   endtask

   task automatic add_row(ple_pkg::mode_type m, int pos, logic [WORD_W-1:0] v, logic typed,
                          logic [WORD_W-1:0] rd, logic fnd, int cnt,
                          ple_pkg::status_type st);
      script_row_type row;
      row.req.mode = m;
      row.req.position = 5'(pos);
      row.req.value = v;
      row.typed = typed;
      row.rsp.read_value = rd;
      row.rsp.found = fnd;
      row.rsp.entry_count = 5'(cnt);
      row.rsp.status = st;
      script_rows.push_back(row);
   endtask

   // Mostly well-formed requests; the list swings between full and empty.
   task automatic next_req(output list_req_type r);
      int pick;
      int hi;
      int k;
      pick = $urandom_range(99);
      if (list_count == LIST_CAP && $urandom_range(3) == 0)
         filling = 1'b0;
      if (list_count == 0 && $urandom_range(2) == 0)
         filling = 1'b1;
      if (filling)
         r.mode = pick < 60 ? ple_pkg::MODE_INSERT : pick < 70 ? ple_pkg::MODE_REMOVE :
                  pick < 85 ? ple_pkg::MODE_GET : ple_pkg::MODE_CONTAINS;
      else
         r.mode = pick < 10 ? ple_pkg::MODE_INSERT : pick < 65 ? ple_pkg::MODE_REMOVE :
                  pick < 82 ? ple_pkg::MODE_GET : ple_pkg::MODE_CONTAINS;
      hi = (r.mode == ple_pkg::MODE_INSERT) ? list_count + 1 : list_count;
      if (hi == 0 || $urandom_range(99) < 15)
         r.position = 5'($urandom_range(31));
      else
         r.position = 5'($urandom_range(hi, 1));
      k = $urandom_range(9);
      r.value = $urandom;
      if (r.mode == ple_pkg::MODE_CONTAINS && list_count > 0 && k < 6)
         r.value = list_words[$urandom_range(list_count - 1)];
      else if (k == 7)
         r.value = '0;
      else if (k == 8)
         r.value = '1;
      else if (k == 9)
         r.value = $urandom_range(15);
   endtask

   // Offer one request and hold it until the transfer; called at a falling edge.
   task automatic send_req(input list_req_type r, input logic typed,
                           input list_rsp_type typed_rsp);
      list_rsp_type want;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= r.mode;
      req_position <= r.position;
      req_value <= r.value;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      list_apply(r, want);
      if (typed)
         want = typed_rsp;
      pending_rsps.push_back(want);
      @(negedge clock);
   endtask

   // Receiver: random stall, plus a long hold-off when asked.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left == 0 && holds_done != holds_asked) begin
            hold_left = HOLD_LEN;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsps.size() == 0) begin
            report_mismatch("transfer with nothing pending", WORD_W'(rsp_status), '0);
         end else begin
            arrived = pending_rsps.pop_front();
            if (rsp_read_value !== arrived.read_value)
               report_mismatch("read_value", rsp_read_value, arrived.read_value);
            if (rsp_found !== arrived.found)
               report_mismatch("found", WORD_W'(rsp_found), WORD_W'(arrived.found));
            if (rsp_entry_count !== arrived.entry_count)
               report_mismatch("entry_count", WORD_W'(rsp_entry_count),
                               WORD_W'(arrived.entry_count));
            if (rsp_status !== arrived.status)
               report_mismatch("status", WORD_W'(rsp_status), WORD_W'(arrived.status));
         end
      end
   end

   initial begin
      list_req_type rq;
      list_rsp_type none;
      int phase;
      none = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // mode, pos, value, typed, read word, found, count, status
      add_row(ple_pkg::MODE_GET, 1, 32'h0, 1, 32'h0, 0, 0, ple_pkg::STATUS_EMPTY);
      add_row(ple_pkg::MODE_REMOVE, 1, 32'h0, 1, 32'h0, 0, 0, ple_pkg::STATUS_EMPTY);
      add_row(ple_pkg::MODE_CONTAINS, 0, 32'h0, 1, 32'h0, 0, 0, ple_pkg::STATUS_OK);
      add_row(ple_pkg::MODE_INSERT, 31, 32'hFFFF_FFFF, 1, 32'h0, 0, 1, ple_pkg::STATUS_OK);
      add_row(ple_pkg::MODE_INSERT, 0, 32'h1111_1111, 1, 32'h0, 0, 1,
              ple_pkg::STATUS_BAD_POS);
      add_row(ple_pkg::MODE_INSERT, 3, 32'h2222_2222, 1, 32'h0, 0, 1,
              ple_pkg::STATUS_BAD_POS);
      add_row(ple_pkg::MODE_GET, 1, 32'h0, 1, 32'hFFFF_FFFF, 0, 1, ple_pkg::STATUS_OK);
      add_row(ple_pkg::MODE_GET, 0, 32'h0, 1, 32'h0, 0, 1, ple_pkg::STATUS_BAD_POS);
      add_row(ple_pkg::MODE_GET, 2, 32'h0, 1, 32'h0, 0, 1, ple_pkg::STATUS_BAD_POS);
      add_row(ple_pkg::MODE_REMOVE, 2, 32'h0, 1, 32'h0, 0, 1, ple_pkg::STATUS_BAD_POS);
      add_row(ple_pkg::MODE_REMOVE, 0, 32'h0, 1, 32'h0, 0, 1, ple_pkg::STATUS_BAD_POS);
      add_row(ple_pkg::MODE_CONTAINS, 0, 32'hFFFF_FFFF, 1, 32'h0, 1, 1, ple_pkg::STATUS_OK);
      add_row(ple_pkg::MODE_INSERT, 1, 32'h0000_0000, 0, 32'h0, 0, 0, ple_pkg::STATUS_OK);
      add_row(ple_pkg::MODE_INSERT, 3, 32'h1234_5678, 0, 32'h0, 0, 0, ple_pkg::STATUS_OK);
      add_row(ple_pkg::MODE_INSERT, 2, 32'hA5A5_5A5A, 0, 32'h0, 0, 0, ple_pkg::STATUS_OK);
      add_row(ple_pkg::MODE_INSERT, 4, 32'h8000_0001, 0, 32'h0, 0, 0, ple_pkg::STATUS_OK);
      add_row(ple_pkg::MODE_GET, 2, 32'h0, 0, 32'h0, 0, 0, ple_pkg::STATUS_OK);
      add_row(ple_pkg::MODE_GET, 5, 32'h0, 0, 32'h0, 0, 0, ple_pkg::STATUS_OK);
      add_row(ple_pkg::MODE_REMOVE, 2, 32'h0, 0, 32'h0, 0, 0, ple_pkg::STATUS_OK);
      add_row(ple_pkg::MODE_GET, 1, 32'h0, 0, 32'h0, 0, 0, ple_pkg::STATUS_OK);
      add_row(ple_pkg::MODE_CONTAINS, 0, 32'hA5A5_5A5A, 0, 32'h0, 0, 0, ple_pkg::STATUS_OK);
      add_row(ple_pkg::MODE_REMOVE, 5, 32'h0, 0, 32'h0, 0, 0, ple_pkg::STATUS_OK);
      add_row(ple_pkg::MODE_REMOVE, 4, 32'h0, 0, 32'h0, 0, 0, ple_pkg::STATUS_OK);
      add_row(ple_pkg::MODE_REMOVE, 1, 32'h0, 0, 32'h0, 0, 0, ple_pkg::STATUS_OK);
      add_row(ple_pkg::MODE_CONTAINS, 0, 32'h0, 0, 32'h0, 0, 0, ple_pkg::STATUS_OK);

      foreach (script_rows[k])
         send_req(script_rows[k].req, script_rows[k].typed, script_rows[k].rsp);

      for (phase = 0; phase < 4; phase++) begin
         // drop valid and drain before changing the idling pattern
         req_valid <= 1'b0;
         while (pending_rsps.size() != 0)
            @(negedge clock);
         case (phase)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 62; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 62; end
            default: begin gap_pct = 29; stall_pct = 29; end
         endcase
         if (phase == 0)
            holds_asked++;
         repeat (100) begin
            next_req(rq);
            send_req(rq, 1'b0, none);
         end
      end

      req_valid <= 1'b0;
      while (pending_rsps.size() != 0)
         @(negedge clock);
      repeat (3 * LIST_CAP) @(negedge clock);
      if (errors == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
